/* src/rssr_pkg.sv */
// ----------------------------------------------------------------------------
// rssr_pkg: shared types and constants of the rotated supersample resampler.
// Holds the command and register codes, the fixed field widths and the
// status word that the sample walker hands to the core.
// ----------------------------------------------------------------------------
package rssr_pkg;

  // Fixed field widths.
  localparam int ORIGIN_W  = 32;
  localparam int STEP_W    = 25;
  localparam int SIZE_W    = 9;
  localparam int WALK_W    = 40;
  localparam int CH_W      = 8;
  localparam int TEXEL_W   = 3 * CH_W;
  localparam int IN_DATA_W = 48;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Sample coordinates carry the walk position plus two guard bits for the sub-step offsets.
  localparam int COORD_W   = WALK_W + 2;

  // Shared reciprocal multiplier: operand, constant and product split point.
  localparam int MUL_A_W   = 25;
  localparam int MUL_M_W   = 28;
  localparam int MUL_SHIFT = 28;

  // Command codes carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RENDER  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_STEP_X_PIX = 3'd2,
    REG_STEP_Y_PIX = 3'd3,
    REG_STEP_X_ROW = 3'd4,
    REG_STEP_Y_ROW = 3'd5,
    REG_SRC_W      = 3'd6,
    REG_SRC_H      = 3'd7
  } cfg_reg_e;

  // Status of the sample walker toward the core.
  typedef struct packed {
    logic vld;
    logic last;
  } smp_stat_t;

endpackage

/* src/rssr_ram.sv */
// ----------------------------------------------------------------------------
// rssr_ram: generic single-port RAM.
// One write per cycle at a shared address, which is also read every cycle;
// read data is registered.
// ----------------------------------------------------------------------------
module rssr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/rssr_sample_walk.sv */
// ----------------------------------------------------------------------------
// rssr_sample_walk: walks the GRID x GRID sample grid of one pixel.
// Starting from the base point it adds the per-pixel sub-steps along a row
// and the per-row sub-steps between rows, clamps each sample to the source
// and presents one texture address per cycle.
// ----------------------------------------------------------------------------
module rssr_sample_walk import rssr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int GRID       = 5,
  parameter int ADDR_W     = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WALK_W-1:0] base_x,
  input  logic signed [WALK_W-1:0] base_y,
  input  logic signed [STEP_W-1:0] sub_xx,
  input  logic signed [STEP_W-1:0] sub_xy,
  input  logic signed [STEP_W-1:0] sub_yx,
  input  logic signed [STEP_W-1:0] sub_yy,
  input  logic [SIZE_W-1:0]        lim_w,
  input  logic [SIZE_W-1:0]        lim_h,
  output smp_stat_t                stat,
  output logic [ADDR_W-1:0]        rd_addr
);

  localparam int SW = COORD_W - FRAC_BITS;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int GW = $clog2(GRID);
  localparam int EXT_B = COORD_W - WALK_W;
  localparam int EXT_S = COORD_W - STEP_W;
  localparam logic [GW-1:0]     LAST_J    = GW'(GRID - 1);
  localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

  logic                      run_r;
  logic [GW-1:0]             jx_r;
  logic [GW-1:0]             jy_r;
  logic signed [COORD_W-1:0] row_x_r;
  logic signed [COORD_W-1:0] row_y_r;
  logic signed [COORD_W-1:0] cur_x_r;
  logic signed [COORD_W-1:0] cur_y_r;
  logic [XW-1:0]             px_r;
  logic [YW-1:0]             py_r;
  logic                      vld_r;
  logic                      last_r;
  logic signed [COORD_W-1:0] sxx_e;
  logic signed [COORD_W-1:0] sxy_e;
  logic signed [COORD_W-1:0] syx_e;
  logic signed [COORD_W-1:0] syy_e;
  logic signed [COORD_W-1:0] nrow_x;
  logic signed [COORD_W-1:0] nrow_y;
  logic                      row_end;
  logic [SW-1:0]             clamp_x;
  logic [SW-1:0]             clamp_y;

  // Integer part of a coordinate, held to the range [0, lim - 1].
  function automatic logic [SW-1:0] clamp_f(input logic [COORD_W-1:0] c,
                                            input logic [SIZE_W-1:0]  lim);
    logic [SW-1:0] s;
    logic [SW-1:0] hi;
    s  = c[COORD_W-1:FRAC_BITS];
    hi = SW'(lim - SIZE_W'(1));
    if (c[COORD_W-1]) begin
      clamp_f = '0;
    end else if (s >= SW'(lim)) begin
      clamp_f = hi;
    end else begin
      clamp_f = s;
    end
  endfunction

  // Sub-steps widened to coordinate width, and the next row start.
  assign sxx_e   = {{EXT_S{sub_xx[STEP_W-1]}}, sub_xx};
  assign sxy_e   = {{EXT_S{sub_xy[STEP_W-1]}}, sub_xy};
  assign syx_e   = {{EXT_S{sub_yx[STEP_W-1]}}, sub_yx};
  assign syy_e   = {{EXT_S{sub_yy[STEP_W-1]}}, sub_yy};
  assign nrow_x  = row_x_r + syx_e;
  assign nrow_y  = row_y_r + syy_e;
  assign row_end = (jx_r == LAST_J);
  assign clamp_x = clamp_f(cur_x_r, lim_w);
  assign clamp_y = clamp_f(cur_y_r, lim_h);

  // Grid sequencer: one sample per cycle while running.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      vld_r  <= 1'b0;
      last_r <= 1'b0;
      jx_r   <= '0;
      jy_r   <= '0;
    end else begin
      vld_r  <= run_r;
      last_r <= run_r && row_end && (jy_r == LAST_J);
      px_r   <= clamp_x[XW-1:0];
      py_r   <= clamp_y[YW-1:0];
      if (start) begin
        run_r   <= 1'b1;
        jx_r    <= '0;
        jy_r    <= '0;
        row_x_r <= {{EXT_B{base_x[WALK_W-1]}}, base_x};
        row_y_r <= {{EXT_B{base_y[WALK_W-1]}}, base_y};
        cur_x_r <= {{EXT_B{base_x[WALK_W-1]}}, base_x};
        cur_y_r <= {{EXT_B{base_y[WALK_W-1]}}, base_y};
      end else if (run_r) begin
        if (row_end) begin
          jx_r    <= '0;
          jy_r    <= jy_r + GW'(1);
          row_x_r <= nrow_x;
          row_y_r <= nrow_y;
          cur_x_r <= nrow_x;
          cur_y_r <= nrow_y;
          if (jy_r == LAST_J) begin
            run_r <= 1'b0;
          end
        end else begin
          jx_r    <= jx_r + GW'(1);
          cur_x_r <= cur_x_r + sxx_e;
          cur_y_r <= cur_y_r + sxy_e;
        end
      end
    end
  end

  // Texture address of the clamped sample.
  assign rd_addr   = ADDR_W'(py_r) * ROW_PITCH + ADDR_W'(px_r);
  assign stat.vld  = vld_r;
  assign stat.last = last_r;

endmodule

/* src/rotated_5x5_supersample_resampler_core.sv */
// ----------------------------------------------------------------------------
// rotated_5x5_supersample_resampler_core: affine texture resampler, box filter.
// Writes, restarts and unused commands are taken while idle. A render moves to its
// base point, divides the sub-steps, makes 25 single-port texture reads (none when
// outside) and averages in a shared multiplier; the next word is taken as the result
// shows. Sync active-low reset clears control, sets config defaults; texture is kept.
// ----------------------------------------------------------------------------
module rotated_5x5_supersample_resampler_core import rssr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int GRID       = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input words.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,  // texel_col, texel_row, in_red, in_green,
                                          // in_blue, new_row, zero pad
  input  logic [1:0]           in_tuser,  // cmd
  // Result words.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TEXEL_W-1:0]   out_tdata, // out_red, out_green, out_blue
  output logic [0:0]           out_tuser, // outside
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SUM_W  = $clog2(GRID * GRID * 255 + 1);
  localparam int FX_W   = WALK_W - FRAC_BITS;
  localparam int EXT_O  = WALK_W - ORIGIN_W;
  localparam int EXT_S  = WALK_W - STEP_W;
  localparam logic [MUL_M_W-1:0] SUB_MULT =
    MUL_M_W'(((1 << MUL_SHIFT) + GRID - 1) / GRID);
  localparam logic [MUL_M_W-1:0] AVG_MULT =
    MUL_M_W'(((1 << MUL_SHIFT) + GRID * GRID - 1) / (GRID * GRID));
  localparam logic [SIZE_W-1:0] MAX_W9    = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H9    = SIZE_W'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_SAMPLE,
    S_AVG,
    S_DONE
  } state_t;

  state_t                     state_r;
  logic [2:0]                 cnt_r;
  logic                       first_r;
  logic                       new_row_r;
  logic                       outside_r;
  logic                       out_vld_r;
  logic [TEXEL_W-1:0]         out_data_r;
  logic                       out_user_r;

  logic signed [ORIGIN_W-1:0] origin_x_r;
  logic signed [ORIGIN_W-1:0] origin_y_r;
  logic signed [STEP_W-1:0]   step_r [4];
  logic [SIZE_W-1:0]          src_w_r;
  logic [SIZE_W-1:0]          src_h_r;

  logic signed [WALK_W-1:0]   walk_x_r;
  logic signed [WALK_W-1:0]   walk_y_r;
  logic signed [WALK_W-1:0]   row_x_r;
  logic signed [WALK_W-1:0]   row_y_r;
  logic signed [STEP_W-1:0]   sub_r [4];
  logic [SUM_W-1:0]           sum_r [3];
  logic [CH_W-1:0]            avg_r [3];

  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_M_W-1:0]         mul_m;
  logic                       mul_neg;
  logic [MUL_A_W+MUL_M_W-1:0] prod_r;
  logic                       prod_neg_r;
  logic [STEP_W-1:0]          sub_mag;
  logic signed [STEP_W-1:0]   sub_q;
  logic signed [STEP_W-1:0]   step_sel;

  logic                       in_acc;
  cmd_e                       cmd;
  logic [7:0]                 texel_col;
  logic [7:0]                 texel_row;
  logic [CH_W-1:0]            in_red;
  logic [CH_W-1:0]            in_green;
  logic [CH_W-1:0]            in_blue;
  logic                       new_row;
  logic                       tex_we;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          ram_addr;
  logic [TEXEL_W-1:0]         ram_rdata;

  logic [SIZE_W-1:0]          src_w_eff;
  logic [SIZE_W-1:0]          src_h_eff;
  logic signed [WALK_W-1:0]   origin_x_e;
  logic signed [WALK_W-1:0]   origin_y_e;
  logic signed [WALK_W-1:0]   pix_x;
  logic signed [WALK_W-1:0]   pix_y;
  logic signed [WALK_W-1:0]   nrow_x;
  logic signed [WALK_W-1:0]   nrow_y;
  logic                       outside_c;
  logic                       smp_start;
  smp_stat_t                  smp_stat;
  logic [ADDR_W-1:0]          smp_addr;
  logic                       rd_vld_r;
  logic                       rd_last_r;

  // Input word fields.
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_e'(in_tuser);
  assign texel_col = in_tdata[7:0];
  assign texel_row = in_tdata[15:8];
  assign in_red    = in_tdata[23:16];
  assign in_green  = in_tdata[31:24];
  assign in_blue   = in_tdata[39:32];
  assign new_row   = in_tdata[40];
  assign in_tready = (state_r == S_IDLE);

  // Texel writes go straight to the memory in the accepting cycle.
  assign tex_we   = in_acc && (cmd == CMD_WRITE) && (32'(texel_col) < MAX_WIDTH) &&
                    (32'(texel_row) < MAX_HEIGHT);
  assign wr_addr  = ADDR_W'(texel_row) * ROW_PITCH + ADDR_W'(texel_col);
  assign ram_addr = tex_we ? wr_addr : smp_addr;

  rssr_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_texture (
    .clk   (clk),
    .we    (tex_we),
    .addr  (ram_addr),
    .wdata ({in_red, in_green, in_blue}),
    .rdata (ram_rdata)
  );

  // Source size saturated to the memory's dimensions.
  assign src_w_eff = (32'(src_w_r) > MAX_WIDTH)  ? MAX_W9 : src_w_r;
  assign src_h_eff = (32'(src_h_r) > MAX_HEIGHT) ? MAX_H9 : src_h_r;

  // Walk arithmetic: origin load, per-pixel step and per-row step.
  assign origin_x_e = {{EXT_O{origin_x_r[ORIGIN_W-1]}}, origin_x_r};
  assign origin_y_e = {{EXT_O{origin_y_r[ORIGIN_W-1]}}, origin_y_r};
  assign pix_x      = walk_x_r + {{EXT_S{step_r[0][STEP_W-1]}}, step_r[0]};
  assign pix_y      = walk_y_r + {{EXT_S{step_r[1][STEP_W-1]}}, step_r[1]};
  assign nrow_x     = row_x_r  + {{EXT_S{step_r[2][STEP_W-1]}}, step_r[2]};
  assign nrow_y     = row_y_r  + {{EXT_S{step_r[3][STEP_W-1]}}, step_r[3]};

  // Base point outside the source.
  assign outside_c = walk_x_r[WALK_W-1] || walk_y_r[WALK_W-1] ||
                     (src_w_eff == '0) || (src_h_eff == '0) ||
                     (walk_x_r[WALK_W-1:FRAC_BITS] >= FX_W'(src_w_eff)) ||
                     (walk_y_r[WALK_W-1:FRAC_BITS] >= FX_W'(src_h_eff));

  // Shared reciprocal multiplier: sub-step division, then the grid average.
  assign step_sel = step_r[cnt_r[1:0]];

  always_comb begin
    mul_a   = '0;
    mul_m   = SUB_MULT;
    mul_neg = 1'b0;
    case (state_r)
      S_DIV: begin
        if (!cnt_r[2]) begin
          mul_neg = step_sel[STEP_W-1];
          mul_a   = mul_neg ? MUL_A_W'(-step_sel) : MUL_A_W'(step_sel);
        end
      end
      S_AVG: begin
        if (cnt_r[1:0] != 2'd3) begin
          mul_a = MUL_A_W'(sum_r[cnt_r[1:0]]);
        end
        mul_m = AVG_MULT;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_m;
    prod_neg_r <= mul_neg;
  end

  assign sub_mag = prod_r[MUL_SHIFT +: STEP_W];
  assign sub_q   = prod_neg_r ? -signed'(sub_mag) : signed'(sub_mag);

  // Grid walk starts once the last sub-step is in.
  assign smp_start = (state_r == S_DIV) && (cnt_r == 3'd4) && !outside_r;

  rssr_sample_walk #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRID       (GRID),
    .ADDR_W     (ADDR_W)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (smp_start),
    .base_x  (walk_x_r),
    .base_y  (walk_y_r),
    .sub_xx  (sub_r[0]),
    .sub_xy  (sub_r[1]),
    .sub_yx  (sub_r[2]),
    .sub_yy  (sub_r[3]),
    .lim_w   (src_w_eff),
    .lim_h   (src_h_eff),
    .stat    (smp_stat),
    .rd_addr (smp_addr)
  );

  // Read data valid tracks the walker, registered to line up with the memory's registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= smp_stat.vld;
      rd_last_r <= smp_stat.last;
    end
  end

  // Sequencer, configuration registers, walk state and result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      first_r    <= 1'b1;
      out_vld_r  <= 1'b0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_r[0]  <= STEP_W'(65536);
      step_r[1]  <= '0;
      step_r[2]  <= '0;
      step_r[3]  <= STEP_W'(65536);
      src_w_r    <= SIZE_W'(256);
      src_h_r    <= SIZE_W'(256);
      walk_x_r   <= '0;
      walk_y_r   <= '0;
      row_x_r    <= '0;
      row_y_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_addr))
          REG_ORIGIN_X:   origin_x_r <= cfg_wdata;
          REG_ORIGIN_Y:   origin_y_r <= cfg_wdata;
          REG_STEP_X_PIX: step_r[0]  <= cfg_wdata[STEP_W-1:0];
          REG_STEP_Y_PIX: step_r[1]  <= cfg_wdata[STEP_W-1:0];
          REG_STEP_X_ROW: step_r[2]  <= cfg_wdata[STEP_W-1:0];
          REG_STEP_Y_ROW: step_r[3]  <= cfg_wdata[STEP_W-1:0];
          REG_SRC_W:      src_w_r    <= cfg_wdata[SIZE_W-1:0];
          REG_SRC_H:      src_h_r    <= cfg_wdata[SIZE_W-1:0];
          default:        src_h_r    <= src_h_r;
        endcase
      end

      if (out_tvalid && out_tready) begin
        out_vld_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (cmd)
              CMD_RENDER: begin
                new_row_r <= new_row;
                state_r   <= S_WALK;
              end
              CMD_RESTART: first_r <= 1'b1;
              default:     first_r <= first_r;
            endcase
          end
        end

        // Move the walk to this pixel's base point.
        S_WALK: begin
          if (first_r) begin
            row_x_r  <= origin_x_e;
            row_y_r  <= origin_y_e;
            walk_x_r <= origin_x_e;
            walk_y_r <= origin_y_e;
          end else if (new_row_r) begin
            row_x_r  <= nrow_x;
            row_y_r  <= nrow_y;
            walk_x_r <= nrow_x;
            walk_y_r <= nrow_y;
          end else begin
            walk_x_r <= pix_x;
            walk_y_r <= pix_y;
          end
          first_r <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        // Four sub-steps through the multiplier; the base check rides along.
        S_DIV: begin
          if (cnt_r == 3'd0) begin
            outside_r <= outside_c;
          end else begin
            sub_r[2'(cnt_r - 3'd1)] <= sub_q;
          end
          if (cnt_r == 3'd4) begin
            cnt_r    <= '0;
            sum_r[0] <= '0;
            sum_r[1] <= '0;
            sum_r[2] <= '0;
            state_r  <= outside_r ? S_DONE : S_SAMPLE;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end

        // Accumulate the texels as they come back from the memory.
        S_SAMPLE: begin
          if (rd_vld_r) begin
            sum_r[0] <= sum_r[0] + SUM_W'(ram_rdata[23:16]);
            sum_r[1] <= sum_r[1] + SUM_W'(ram_rdata[15:8]);
            sum_r[2] <= sum_r[2] + SUM_W'(ram_rdata[7:0]);
            if (rd_last_r) begin
              cnt_r   <= '0;
              state_r <= S_AVG;
            end
          end
        end

        // Divide the three sums by the sample count.
        S_AVG: begin
          if (cnt_r != 3'd0) begin
            avg_r[2'(cnt_r - 3'd1)] <= prod_r[MUL_SHIFT +: CH_W];
          end
          if (cnt_r == 3'd3) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r  <= 1'b1;
            out_data_r <= outside_r ? '0 : {avg_r[2], avg_r[1], avg_r[0]};
            out_user_r <= outside_r;
            state_r    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

`ifndef SYNTHESIS
  // The grid walker only runs while the core gathers samples.
  a_walk_in_sample: assert property (@(posedge clk) disable iff (!rst_n)
    smp_stat.vld |-> (state_r == S_SAMPLE))
    else $error("sample walker active outside the sampling phase");

  // An outside result carries zero colour.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("outside result with nonzero colour");

  // A new result word is only loaded from the final state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside the final state");

  // The first-pixel mark is consumed only by a walk update.
  a_first_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(state_r == S_WALK))
    else $error("first-pixel mark cleared without a walk update");
`endif

endmodule
